[hw/rtl/nctt_pkg.sv]
// Shared types and constants for the note code to tone timing block.
// Holds the item structs, the decoded-note struct and the tone period table.
// No dependencies.
package nctt_pkg;

  localparam int unsigned PeriodW = 22;
  localparam int unsigned MsW     = 12;
  localparam int unsigned VolW    = 10;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [VolW-1:0] VolFull     = 10'd1000;
  localparam logic [VolW-1:0] VolReset    = 10'd50;
  localparam logic [MsW-1:0]  WholeNoteMs = 12'd1600;

  // register index, taken from paddr[2]
  localparam logic RegVolume = 1'b0;

  typedef enum logic [1:0] {
    ArticNormal,
    ArticLegato,
    ArticStaccato
  } nctt_artic_e;

  typedef struct packed {
    logic [7:0] pitch_code;
    logic [7:0] length_code;
  } nctt_in_t;

  typedef struct packed {
    logic [PeriodW-1:0] period_ns;
    logic [PeriodW-1:0] pulse_ns;
    logic [MsW-1:0]     sound_ms;
    logic [MsW-1:0]     silence_ms;
    logic               is_rest;
    logic               bad_code;
  } nctt_out_t;

  typedef struct packed {
    logic        bad;
    logic [3:0]  idx;
    logic [1:0]  zone_shift;
    logic [2:0]  divd;
    nctt_artic_e artic;
    logic [1:0]  dot;
  } nctt_dec_t;

  // floor(1e9 / tone) for the lowest zone; zero marks a rest
  function automatic logic [PeriodW-1:0] period_base(logic [3:0] idx);
    logic [PeriodW-1:0] p;
    unique case (idx)
      4'd0, 4'd1:   p = 22'd0;
      4'd2:         p = 22'd3816793;
      4'd3:         p = 22'd3610108;
      4'd4:         p = 22'd3401360;
      4'd5:         p = 22'd3215434;
      4'd6, 4'd7:   p = 22'd3030303;
      4'd8:         p = 22'd2865329;
      4'd9:         p = 22'd2702702;
      4'd10:        p = 22'd2551020;
      4'd11:        p = 22'd2409638;
      4'd12:        p = 22'd2272727;
      4'd13:        p = 22'd2145922;
      4'd14, 4'd15: p = 22'd2024291;
      default:      p = 22'd0;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/nctt_decode.sv]
// Digit decoder: splits pitch and length codes into decimal digits and
// checks them against the tone, zone and division ranges. Uses nctt_pkg.
module nctt_decode import nctt_pkg::*; (
  input  nctt_in_t  item_i,
  output nctt_dec_t dec_o
);

  // {hundreds, tens, ones}; reciprocal multiplies, exact for 8-bit values
  function automatic logic [11:0] digits(logic [7:0] v);
    logic [15:0] m10;
    logic [13:0] m100;
    logic [4:0]  q10;
    logic [1:0]  q100;
    logic [7:0]  ones;
    logic [4:0]  tens;
    m10  = {8'b0, v} * 16'd205;
    m100 = {6'b0, v} * 14'd41;
    q10  = m10[15:11];
    q100 = m100[13:12];
    ones = v - {q10, 3'b0} - {2'b0, q10, 1'b0};
    tens = q10 - {q100, 3'b0} - {2'b0, q100, 1'b0};
    return {2'b0, q100, tens[3:0], ones[3:0]};
  endfunction

  logic [11:0] p_dig, l_dig;
  logic [3:0]  note, zone, semi, divd, artic, dot;
  logic [4:0]  idx;

  assign p_dig = digits(item_i.pitch_code);
  assign l_dig = digits(item_i.length_code);
  assign note  = p_dig[3:0];
  assign zone  = p_dig[7:4];
  assign semi  = p_dig[11:8];
  assign divd  = l_dig[3:0];
  assign artic = l_dig[7:4];
  assign dot   = l_dig[11:8];
  assign idx   = {note, 1'b0} + {1'b0, semi};

  always_comb begin
    dec_o.bad        = (zone == 4'd0) || (zone > 4'd3) || (divd > 4'd6) || (idx > 5'd15);
    dec_o.idx        = idx[3:0];
    dec_o.zone_shift = zone[1:0] - 2'd1;
    dec_o.divd       = divd[2:0];
    dec_o.dot        = dot[1:0];
    if (artic == 4'd0) begin
      dec_o.artic = ArticNormal;
    end else if (artic == 4'd2) begin
      dec_o.artic = ArticStaccato;
    end else begin
      dec_o.artic = ArticLegato;
    end
  end

endmodule

[hw/rtl/note_code_to_tone_timing.sv]
// Top level of the note code to tone timing block: APB volume register and
// a four-stage note pipeline. Uses nctt_pkg and nctt_decode.
//
// One note item enters per clock unless out_ready_i stalls the pipeline.
// Stages: digit decode, tone table lookup and note length, volume-by-period
// multiply with articulation scaling, and the divide by 1000 done as a
// reciprocal multiply. The only stall comes from out_ready_i; a held result
// backs up the stages behind it. Volume is sampled when a note reaches the
// second stage.
module note_code_to_tone_timing import nctt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  nctt_in_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nctt_out_t        out_item_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [VolW-1:0] volume_q;
  logic            rdy1, rdy2, rdy3, rdy4;
  logic            v1_q, v2_q, v3_q, v4_q;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegVolume) ? {{(DataW-VolW){1'b0}}, volume_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= VolReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegVolume)) begin
      volume_q <= pwdata[VolW-1:0];
    end
  end

  // flow control
  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: digit decode
  nctt_dec_t dec_d, dec1_q;

  nctt_decode u_decode (
    .item_i (in_item_i),
    .dec_o  (dec_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy1) dec1_q <= dec_d;
  end

  // stage 2: period lookup, note length, volume clamp
  logic [PeriodW-1:0] pbase;
  logic [PeriodW-1:0] period2_d, period2_q;
  logic [MsW-1:0]     base_ms, total2_d, total2_q;
  logic [VolW-1:0]    vol2_d, vol2_q;
  logic               rest2_q, bad2_q;
  nctt_artic_e        artic2_q;

  always_comb begin
    pbase     = period_base(dec1_q.idx);
    period2_d = pbase >> dec1_q.zone_shift;
    base_ms   = WholeNoteMs >> dec1_q.divd;
    if (dec1_q.dot == 2'd0) begin
      total2_d = base_ms;
    end else if (dec1_q.dot == 2'd1) begin
      total2_d = base_ms + (base_ms >> 1);
    end else begin
      total2_d = {base_ms[MsW-2:0], 1'b0};
    end
    vol2_d = (volume_q > VolFull) ? VolFull : volume_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      period2_q <= period2_d;
      total2_q  <= total2_d;
      vol2_q    <= vol2_d;
      rest2_q   <= (pbase == '0);
      bad2_q    <= dec1_q.bad;
      artic2_q  <= dec1_q.artic;
    end
  end

  // stage 3: volume * period, articulation
  logic [31:0]        prod3_d, prod3_q;
  logic [27:0]        m45;
  logic [MsW-1:0]     sound3_d, sound3_q, total3_q;
  logic [PeriodW-1:0] period3_q;
  logic               rest3_q, bad3_q;

  always_comb begin
    prod3_d = {22'b0, vol2_q} * {10'b0, period2_q};
    // total*4/5 as (4*total) * ceil(2^16/5) >> 16
    m45     = {14'b0, total2_q, 2'b0} * 28'd13108;
    unique case (artic2_q)
      ArticNormal:   sound3_d = m45[27:16];
      ArticStaccato: sound3_d = total2_q >> 1;
      default:       sound3_d = total2_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      prod3_q   <= prod3_d;
      sound3_q  <= sound3_d;
      total3_q  <= total2_q;
      period3_q <= period2_q;
      rest3_q   <= rest2_q;
      bad3_q    <= bad2_q;
    end
  end

  // stage 4: prod / 1000 = (prod >> 3) * ceil(2^36/125) >> 36
  logic [58:0] recip;
  nctt_out_t   out_d, out_q;

  always_comb begin
    recip = {30'b0, prod3_q[31:3]} * 59'd549755814;
    out_d = '0;
    if (bad3_q) begin
      out_d.bad_code = 1'b1;
    end else begin
      out_d.period_ns  = period3_q;
      out_d.pulse_ns   = recip[57:36];
      out_d.sound_ms   = sound3_q;
      out_d.silence_ms = total3_q - sound3_q;
      out_d.is_rest    = rest3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) out_q <= out_d;
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = out_q;

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.bad_code |-> out_item_o.period_ns == '0 &&
      out_item_o.pulse_ns == '0 && out_item_o.sound_ms == '0 &&
      out_item_o.silence_ms == '0 && !out_item_o.is_rest)
    else $error("bad code result carries nonzero fields");

  a_rest_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_rest |-> out_item_o.period_ns == '0 &&
      out_item_o.pulse_ns == '0)
    else $error("rest result has nonzero period or pulse");

  a_pulse_le_period : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.pulse_ns <= out_item_o.period_ns)
    else $error("pulse exceeds period");

  a_note_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_item_o.sound_ms} + {1'b0, out_item_o.silence_ms}) <= 13'd3200)
    else $error("note length out of range");

  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule

[sim/note_code_to_tone_timing_test.sv]
// Testbench for note_code_to_tone_timing: directed note table, then random
// notes over several volume settings, checked against typed table values or
// a local note decoder. Uses nctt_pkg and the note_code_to_tone_timing RTL.
`timescale 1ns / 1ps

module note_code_to_tone_timing_test;
  import nctt_pkg::*;

  localparam int unsigned NsPerS       = 1000000000;
  localparam int unsigned NotesPerSet  = 213;
  localparam int unsigned NumSettings  = 6;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned CycleLimit   = 400000;
  localparam logic [AddrW-1:0] VolAddr = {RegVolume, 2'b00};

  typedef struct {
    nctt_in_t  item;
    bit        typed;
    nctt_out_t want;
  } note_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  nctt_in_t         in_item_i;
  logic             out_valid_o;
  logic             out_ready_i;
  nctt_out_t        out_item_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic [VolW-1:0] vol_setting;
  nctt_out_t       pending_notes[$];
  note_row_t       note_table[$];
  bit              note_typed;
  nctt_out_t       note_typed_res;
  bit              no_idle;
  bit              hold_req;
  int unsigned     mismatches;
  int unsigned     cycle_count;

  note_code_to_tone_timing uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  function automatic nctt_out_t decode_note(nctt_in_t n, logic [VolW-1:0] vol);
    nctt_out_t r;
    int unsigned p, l, note, zone, semi, divd, artic, dot, idx;
    int unsigned tone, freq, total, sound, v, period;
    longint unsigned pulse;
    p     = n.pitch_code;
    l     = n.length_code;
    note  = p % 10;
    zone  = (p / 10) % 10;
    semi  = (p / 100) % 10;
    divd  = l % 10;
    artic = (l / 10) % 10;
    dot   = (l / 100) % 10;
    idx   = note * 2 + semi;
    r     = '0;
    if (zone == 0 || zone > 3 || divd > 6 || idx > 15) begin
      r.bad_code = 1'b1;
      return r;
    end
    case (idx)
      2:       tone = 262;
      3:       tone = 277;
      4:       tone = 294;
      5:       tone = 311;
      6, 7:    tone = 330;
      8:       tone = 349;
      9:       tone = 370;
      10:      tone = 392;
      11:      tone = 415;
      12:      tone = 440;
      13:      tone = 466;
      14, 15:  tone = 494;
      default: tone = 0;
    endcase
    freq  = tone << (zone - 1);
    total = ((int'(WholeNoteMs) >> divd) * (2 + dot)) / 2;
    if (artic == ArticNormal) sound = total * 4 / 5;
    else if (artic == ArticStaccato) sound = total / 2;
    else sound = total;
    if (freq != 0) begin
      v      = (vol > VolFull) ? int'(VolFull) : int'(vol);
      period = NsPerS / freq;
      pulse  = (longint'(v) * period) / 1000;
      r.period_ns = PeriodW'(period);
      r.pulse_ns  = PeriodW'(pulse);
    end else begin
      r.is_rest = 1'b1;
    end
    r.sound_ms   = MsW'(sound);
    r.silence_ms = MsW'(total - sound);
    return r;
  endfunction

  function automatic nctt_in_t random_note();
    nctt_in_t n;
    int unsigned note, semi, zone, l;
    if ($urandom_range(0, 9) < 8) begin
      note = $urandom_range(0, 7);
      semi = (note == 7) ? $urandom_range(0, 1) : $urandom_range(0, 2);
      zone = $urandom_range(1, 3);
      n.pitch_code = 8'(semi * 100 + zone * 10 + note);
      l = $urandom_range(0, 2) * 100 + $urandom_range(0, 9) * 10 + $urandom_range(0, 6);
      if (l > 255) l = l - 100;
      n.length_code = 8'(l);
    end else begin
      n = nctt_in_t'($urandom_range(0, 65535));
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < 100)
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_row(input int unsigned p, input int unsigned l, input bit typed,
                         input int unsigned per, input int unsigned pul,
                         input int unsigned snd, input int unsigned sil,
                         input bit rest, input bit bad);
    note_row_t row;
    row.item.pitch_code  = 8'(p);
    row.item.length_code = 8'(l);
    row.typed            = typed;
    row.want.period_ns   = PeriodW'(per);
    row.want.pulse_ns    = PeriodW'(pul);
    row.want.sound_ms    = MsW'(snd);
    row.want.silence_ms  = MsW'(sil);
    row.want.is_rest     = rest;
    row.want.bad_code    = bad;
    note_table.push_back(row);
  endtask

  // entered and left at a falling edge
  task automatic send_note(input nctt_in_t n, input bit typed, input nctt_out_t want);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_item_i      <= n;
    note_typed     <= typed;
    note_typed_res <= want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_volume(input logic [VolW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= VolAddr;
    pwdata  <= DataW'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    vol_setting = v;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DataW'(v)) report_mismatch("volume readback", prdata, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_notes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CycleLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stall bursts, one long hold on request, always ready when no_idle is set
  initial begin : receiver
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left  = $urandom_range(1, 11) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : scoreboard
    nctt_out_t want;
    if (in_valid_i && in_ready_o)
      pending_notes.push_back(note_typed ? note_typed_res : decode_note(in_item_i, vol_setting));
    if (out_valid_o && out_ready_i) begin
      if (pending_notes.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_notes.pop_front();
        if (out_item_o.period_ns !== want.period_ns)
          report_mismatch("period_ns", out_item_o.period_ns, want.period_ns);
        if (out_item_o.pulse_ns !== want.pulse_ns)
          report_mismatch("pulse_ns", out_item_o.pulse_ns, want.pulse_ns);
        if (out_item_o.sound_ms !== want.sound_ms)
          report_mismatch("sound_ms", out_item_o.sound_ms, want.sound_ms);
        if (out_item_o.silence_ms !== want.silence_ms)
          report_mismatch("silence_ms", out_item_o.silence_ms, want.silence_ms);
        if (out_item_o.is_rest !== want.is_rest)
          report_mismatch("is_rest", out_item_o.is_rest, want.is_rest);
        if (out_item_o.bad_code !== want.bad_code)
          report_mismatch("bad_code", out_item_o.bad_code, want.bad_code);
      end
    end
  end

  initial begin
    nctt_out_t none;
    none           = '0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    note_typed     = 1'b0;
    note_typed_res = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    vol_setting    = VolReset;
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    mismatches     = 0;

    // bad codes: zone 0, zone above 3, division above 6, tone index above 15
    add_row(0,   0,   1, 0, 0, 0, 0, 0, 1);
    add_row(255, 255, 1, 0, 0, 0, 0, 0, 1);
    add_row(11,  7,   1, 0, 0, 0, 0, 0, 1);
    add_row(19,  0,   1, 0, 0, 0, 0, 0, 1);
    add_row(237, 0,   1, 0, 0, 0, 0, 0, 1);
    add_row(40,  0,   1, 0, 0, 0, 0, 0, 1);
    add_row(101, 0,   1, 0, 0, 0, 0, 0, 1);
    // rest, lowest tone at reset volume, shortest division
    add_row(10,  0,   1, 0, 0, 1280, 320, 1, 0);
    add_row(11,  0,   1, 3816793, 190839, 1280, 320, 0, 0);
    add_row(11,  6,   1, 3816793, 190839, 20, 5, 0, 0);
    // zones, dots, articulations, highest tones
    add_row(211, 10,  0, 0, 0, 0, 0, 0, 0);
    add_row(137, 220, 0, 0, 0, 0, 0, 0, 0);
    add_row(37,  206, 0, 0, 0, 0, 0, 0, 0);
    add_row(12,  216, 0, 0, 0, 0, 0, 0, 0);
    add_row(20,  226, 0, 0, 0, 0, 0, 0, 0);
    add_row(30,  196, 0, 0, 0, 0, 0, 0, 0);
    add_row(31,  100, 0, 0, 0, 0, 0, 0, 0);
    add_row(115, 200, 0, 0, 0, 0, 0, 0, 0);
    add_row(214, 230, 0, 0, 0, 0, 0, 0, 0);
    add_row(233, 146, 0, 0, 0, 0, 0, 0, 0);
    add_row(26,  53,  0, 0, 0, 0, 0, 0, 0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (note_table[i]) send_note(note_table[i].item, note_table[i].typed, note_table[i].want);

    for (int unsigned s = 0; s < NumSettings; s++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      case (s)
        0:       set_volume(10'd0);
        1:       set_volume(VolFull);
        2:       set_volume(10'd1023);
        3:       set_volume(10'd1);
        4:       set_volume(VolW'($urandom_range(0, 1023)));
        default: set_volume(VolW'($urandom_range(0, 1000)));
      endcase
      if (s == 1) hold_req = 1'b1;
      if (s == NumSettings - 1) no_idle = 1'b1;
      repeat (NotesPerSet) send_note(random_note(), 1'b0, none);
    end

    in_valid_i <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[note_code_to_tone_timing.f]
hw/rtl/nctt_pkg.sv
hw/rtl/nctt_decode.sv
hw/rtl/note_code_to_tone_timing.sv
sim/note_code_to_tone_timing_test.sv
